// ===== rtl/core/pee_pkg.sv =====
// shared constants, command and status types for the postfix evaluator
// no dependencies; imported by every module of the block
package pee_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned DIV_CNT_W   = $clog2(WORD_W);

  localparam logic [7:0] SYM_ZERO = 8'h30;
  localparam logic [7:0] SYM_NINE = 8'h39;
  localparam logic [7:0] SYM_ADD  = 8'h2B;
  localparam logic [7:0] SYM_SUB  = 8'h2D;
  localparam logic [7:0] SYM_MUL  = 8'h2A;
  localparam logic [7:0] SYM_DIV  = 8'h2F;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_DIV_ZERO = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic pop;
    logic latch_b;
    logic latch_a;
    logic calc;
    logic push;
    logic out_load;
    logic clear;
  } pee_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_digit;
    logic is_div;
    logic last;
    logic div_zero;
    logic div_done;
    logic out_busy;
  } pee_stat_t;

endpackage

// ===== rtl/core/postfix_expression_evaluator_top.sv =====
// postfix expression evaluator: one character per request, result on last char;
// a digit is captured and pushed; + - * or another char pops b and a, runs
// the alu and pushes; '/' waits for the 32-step divider; a last char then
// pops the result into the output register, waiting while that still holds a result
// async active-low reset clears stack count, held result, error and
// output valid; stack contents stay undefined, no clearing pass
// depends on pee_pkg, pee_ctrl, pee_dp, pee_div
module postfix_expression_evaluator_top import pee_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input request: character stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] symbol
  input  logic        s_axis_tlast_i,   // last_symbol
  // result request: one per expression
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // [31:0] value, [33:32] error_code, [39:34] zero
);

  pee_cmd_t          dp_cmd;
  pee_stat_t         dp_stat;
  logic              s_accept;
  logic [WORD_W-1:0] out_value;
  logic [1:0]        out_error;

  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;

  // controller: one character at a time, takes input only in idle
  pee_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // datapath: stack, alu, divider and the output register, which lets the
  // next expression proceed while a result waits to be taken
  pee_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .symbol_i    (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_value_o (out_value),
    .out_error_o (out_error)
  );

  assign m_axis_tdata_o = {6'b0, out_error, out_value};

  // block goes busy right after taking a character
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> !s_axis_tready_o)
    else $error("input taken while previous character in progress");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.out_load |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result register overwritten before taken");

  // divider finishes only while a character is in progress
  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_stat.div_done |-> !s_axis_tready_o)
    else $error("divide completed while idle");

  // at most one stack operation per cycle
  a_stack_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({dp_cmd.push, dp_cmd.pop, dp_cmd.clear}))
    else $error("conflicting stack commands");

endmodule

// ===== rtl/core/pee_div.sv =====
// iterative signed 32-bit divider, one quotient bit per cycle, truncating
// depends on pee_pkg
module pee_div import pee_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WORD_W-1:0] dividend_i,
  input  logic [WORD_W-1:0] divisor_i,
  output logic              done_o,
  output logic [WORD_W-1:0] quotient_o
);

  logic                 busy_q, fix_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 neg_q;
  logic [WORD_W-1:0]    dvd_q, dvs_q, rem_q, quo_q;
  logic [WORD_W:0]      rem_sh, diff;
  logic                 ge;
  logic [WORD_W-1:0]    mag_a, mag_b;

  assign mag_a  = dividend_i[WORD_W-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign mag_b  = divisor_i[WORD_W-1]  ? (~divisor_i + 1'b1)  : divisor_i;
  assign rem_sh = {rem_q, dvd_q[WORD_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = ~diff[WORD_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(WORD_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          fix_q  <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end else if (fix_q) begin
        fix_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // payload: magnitudes shift through, sign applied at the end
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= mag_a;
      dvs_q <= mag_b;
      rem_q <= '0;
      neg_q <= dividend_i[WORD_W-1] ^ divisor_i[WORD_W-1];
    end else if (busy_q) begin
      dvd_q <= {dvd_q[WORD_W-2:0], ge};
      rem_q <= ge ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
    end else if (fix_q) begin
      quo_q <= neg_q ? (~dvd_q + 1'b1) : dvd_q;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/core/pee_dp.sv =====
// datapath: symbol register, indexed stack memory, operand and result
// registers, alu, sticky error and output register; depends on pee_pkg, pee_div
module pee_dp import pee_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pee_cmd_t          cmd_i,
  output pee_stat_t         stat_o,
  input  logic [7:0]        symbol_i,
  input  logic              last_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [WORD_W-1:0] out_value_o,
  output logic [1:0]        out_error_o
);

  logic [WORD_W-1:0] mem_q [STACK_DEPTH];
  logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_dec;
  logic [WORD_W-1:0] rd_q;
  logic              pop_ok_q;
  logic [7:0]        sym_q;
  logic              last_q;
  logic [WORD_W-1:0] a_q, b_q, popped;
  logic [WORD_W-1:0] held_q, held_d, push_val, product;
  err_e              err_q, err_d;
  logic              full, is_digit, div_start, div_done;
  logic [WORD_W-1:0] quotient;
  logic              out_valid_q;
  logic [WORD_W-1:0] out_value_q;
  logic [1:0]        out_error_q;

  assign full     = (cnt_q == CNT_W'(STACK_DEPTH));
  assign cnt_dec  = cnt_q - 1'b1;
  assign popped   = pop_ok_q ? rd_q : '1;
  assign is_digit = (sym_q >= SYM_ZERO) && (sym_q <= SYM_NINE);
  assign push_val = is_digit ? {{(WORD_W-8){1'b0}}, sym_q - SYM_ZERO} : held_q;
  assign product  = a_q * b_q;
  assign div_start = cmd_i.calc && (sym_q == SYM_DIV) && (b_q != '0);

  pee_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (a_q),
    .divisor_i  (b_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    held_d = held_q;
    err_d  = err_q;
    cnt_d  = cnt_q;
    if (cmd_i.calc) begin
      case (sym_q)
        SYM_ADD: held_d = a_q + b_q;
        SYM_SUB: held_d = a_q - b_q;
        SYM_MUL: held_d = product;
        SYM_DIV: begin
          if (b_q == '0) begin
            held_d = '0;
            if (err_q == ERR_NONE) err_d = ERR_DIV_ZERO;
          end
        end
        default: held_d = held_q;
      endcase
    end
    if (div_done) held_d = quotient;
    if (cmd_i.push) begin
      if (full) begin
        if (err_q == ERR_NONE) err_d = ERR_OVERFLOW;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
    if (cmd_i.pop && (cnt_q != '0)) cnt_d = cnt_dec;
    if (cmd_i.clear) begin
      cnt_d  = '0;
      held_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      held_q      <= '0;
      err_q       <= ERR_NONE;
      pop_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      held_q <= held_d;
      err_q  <= err_d;
      if (cmd_i.pop) pop_ok_q <= (cnt_q != '0);
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // stack memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !full) mem_q[cnt_q[ADDR_W-1:0]] <= push_val;
    if (cmd_i.pop && (cnt_q != '0)) rd_q <= mem_q[cnt_dec[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sym_q  <= symbol_i;
      last_q <= last_i;
    end
    if (cmd_i.latch_b) b_q <= popped;
    if (cmd_i.latch_a) a_q <= popped;
    if (cmd_i.out_load) begin
      out_value_q <= popped;
      out_error_q <= err_q;
    end
  end

  assign stat_o.is_digit = is_digit;
  assign stat_o.is_div   = (sym_q == SYM_DIV);
  assign stat_o.last     = last_q;
  assign stat_o.div_zero = (b_q == '0);
  assign stat_o.div_done = div_done;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_error_o = out_error_q;

endmodule

// ===== rtl/core/pee_ctrl.sv =====
// controller state machine sequencing pops, alu, divide, push and output
// depends on pee_pkg
module pee_ctrl import pee_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pee_stat_t stat_i,
  output pee_cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_POP_B    = 9'b000000010,
    ST_POP_A    = 9'b000000100,
    ST_GET_A    = 9'b000001000,
    ST_CALC     = 9'b000010000,
    ST_DIV_WAIT = 9'b000100000,
    ST_PUSH     = 9'b001000000,
    ST_FIN_POP  = 9'b010000000,
    ST_FIN_OUT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_POP_B;
        end
      end
      ST_POP_B: begin
        // digits skip the pops
        if (stat_i.is_digit) begin
          cmd_o.push = 1'b1;
          state_d = stat_i.last ? ST_FIN_POP : ST_IDLE;
        end else begin
          cmd_o.pop = 1'b1;
          state_d = ST_POP_A;
        end
      end
      ST_POP_A: begin
        cmd_o.latch_b = 1'b1;
        cmd_o.pop     = 1'b1;
        state_d = ST_GET_A;
      end
      ST_GET_A: begin
        cmd_o.latch_a = 1'b1;
        state_d = ST_CALC;
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d = (stat_i.is_div && !stat_i.div_zero) ? ST_DIV_WAIT : ST_PUSH;
      end
      ST_DIV_WAIT: begin
        if (stat_i.div_done) state_d = ST_PUSH;
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
        state_d = stat_i.last ? ST_FIN_POP : ST_IDLE;
      end
      ST_FIN_POP: begin
        cmd_o.pop = 1'b1;
        state_d = ST_FIN_OUT;
      end
      ST_FIN_OUT: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          cmd_o.clear    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

endmodule
